// ===== sv/c3e_pkg.sv =====
// ----------------------------------------------------------------------------
// c3e_pkg: shared types and constants of the 3x3 rgb convolution
// pixel and sum widths, register indexes, sequencer states, channel sums
// ----------------------------------------------------------------------------
package c3e_pkg;

   localparam int PIX_W  = 8;
   localparam int COEF_W = 16;
   localparam int SUM_W  = 28;   // nine taps of 8 x 16 bits, signed
   localparam int MAG_W  = 27;   // magnitude of a channel sum
   localparam int DIV_W  = 10;
   localparam int OFF_W  = 11;
   localparam int REG_W  = 48;
   localparam int TAPS   = 9;

   typedef enum logic [2:0] {
      CSR_KERNEL_TOP    = 3'd0,
      CSR_KERNEL_MIDDLE = 3'd1,
      CSR_KERNEL_BOTTOM = 3'd2,
      CSR_ANCHOR        = 3'd3,
      CSR_DIVISOR       = 3'd4,
      CSR_OFFSET        = 3'd5,
      CSR_WIDTH         = 3'd6,
      CSR_HEIGHT        = 3'd7
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_STORE,
      ST_TAPS,
      ST_SUM,
      ST_DIV,
      ST_OUT
   } state_type;

   typedef struct packed {
      logic signed [SUM_W-1:0] red;
      logic signed [SUM_W-1:0] green;
      logic signed [SUM_W-1:0] blue;
   } sum_type;

endpackage

// ===== sv/c3e_cell.sv =====
// ----------------------------------------------------------------------------
// c3e_cell: one tap of the multiply-accumulate chain
// adds its coefficient times the broadcast tap to the partial sums it
// receives and registers the result, handing it to the next cell in the following cycle, not later
// ----------------------------------------------------------------------------
module c3e_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                vld_in,
   input  logic [3*c3e_pkg::PIX_W-1:0]         tap_in,
   input  logic signed [c3e_pkg::COEF_W-1:0]   coef,
   input  c3e_pkg::sum_type                    partial_in,
   output logic                                vld_out,
   output c3e_pkg::sum_type                    partial_out
);

   localparam int PW = c3e_pkg::PIX_W;
   localparam int PR_W = PW + 1 + c3e_pkg::COEF_W;

   logic                    vld_ff;
   c3e_pkg::sum_type        acc_ff, acc_in;
   logic signed [PR_W-1:0]  prod_r, prod_g, prod_b;

   assign prod_r = $signed({1'b0, tap_in[PW-1:0]}) * coef;
   assign prod_g = $signed({1'b0, tap_in[2*PW-1:PW]}) * coef;
   assign prod_b = $signed({1'b0, tap_in[3*PW-1:2*PW]}) * coef;

   always_comb begin
      acc_in.red   = partial_in.red   + c3e_pkg::SUM_W'(prod_r);
      acc_in.green = partial_in.green + c3e_pkg::SUM_W'(prod_g);
      acc_in.blue  = partial_in.blue  + c3e_pkg::SUM_W'(prod_b);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (vld_in) begin
         acc_ff <= acc_in;
      end
   end

   assign vld_out     = vld_ff;
   assign partial_out = acc_ff;

endmodule

// ===== sv/c3e_div.sv =====
// ----------------------------------------------------------------------------
// c3e_div: signed by unsigned divider, truncating toward zero
// restoring division of the magnitude, one quotient bit per cycle
// ----------------------------------------------------------------------------
module c3e_div (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   input  logic signed [c3e_pkg::SUM_W-1:0]    dividend,
   input  logic [c3e_pkg::DIV_W-1:0]           divisor,
   output logic                                done,
   output logic signed [c3e_pkg::SUM_W-1:0]    quotient
);

   localparam int MW = c3e_pkg::MAG_W;
   localparam int DW = c3e_pkg::DIV_W;
   localparam int SW = c3e_pkg::SUM_W;
   localparam int CNT_W = $clog2(MW + 1);

   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DW-1:0]     rem_ff, rem_in;
   logic [MW-1:0]     quo_ff, quo_in;
   logic [DW-1:0]     dvs_ff, dvs_in;
   logic              neg_ff, neg_in;
   logic [SW-1:0]     mag_full;
   logic [DW+1:0]     diff;

   assign mag_full = dividend[SW-1] ? SW'(0) - dividend : dividend;
   assign diff = {1'b0, rem_ff, quo_ff[MW-1]} - {2'b00, dvs_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      dvs_in  = dvs_ff;
      neg_in  = neg_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(MW);
         rem_in  = '0;
         quo_in  = mag_full[MW-1:0];
         dvs_in  = divisor;
         neg_in  = dividend[SW-1];
      end else if (busy_ff) begin
         // trial subtract of the shifted remainder
         if (!diff[DW+1]) begin
            rem_in = diff[DW-1:0];
         end else begin
            rem_in = {rem_ff[DW-2:0], quo_ff[MW-1]};
         end
         quo_in = {quo_ff[MW-2:0], !diff[DW+1]};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      dvs_ff <= dvs_in;
      neg_ff <= neg_in;
   end

   assign done = done_ff;
   assign quotient = neg_ff ? SW'(0) - {1'b0, quo_ff} : {1'b0, quo_ff};

endmodule

// ===== sv/conv3x3_rgb_edge_replicate.sv =====
// ----------------------------------------------------------------------------
// conv3x3_rgb_edge_replicate: 3x3 rgb convolution with replicated edges
// pixels go into a line ring; each output reads nine taps through a chain
// of multiply-accumulate cells, then divides, offsets and saturates
// ----------------------------------------------------------------------------
// a request that gives no result is taken, prepared and stored; one that gives a
// result then reads nine taps on the single ring read port, waits for the end of
// the cell chain, runs the bit-serial dividers and loads the result; one request
// is worked on at a time, and the result register lets the next request in while
// a result waits
// reset is synchronous, clears the counters and loads the register defaults
// ----------------------------------------------------------------------------
module conv3x3_rgb_edge_replicate #(
   parameter int MAX_WIDTH  = 1024,
   parameter int MAX_HEIGHT = 1024
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [23:0]                       req_tdata,   // pixel_red, pixel_green, pixel_blue
   input  logic                              req_tuser,   // drain
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [23:0]                       rsp_tdata,   // out_red, out_green, out_blue
   output logic                              rsp_tlast,
   input  logic                              csr_we,
   input  c3e_pkg::csr_index_type            csr_index,
   input  logic [c3e_pkg::REG_W-1:0]         csr_wdata
);

   localparam int XW = $clog2(MAX_WIDTH);
   localparam int YW = $clog2(MAX_HEIGHT);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int HW = $clog2(MAX_HEIGHT + 1);
   localparam int CW = $clog2(MAX_WIDTH * MAX_HEIGHT + 2 * MAX_WIDTH + 3);
   localparam int AW = $clog2(2 * MAX_WIDTH + 4);
   localparam int RING_DEPTH = 2 ** AW;
   localparam int XS = XW + 2;
   localparam int YS = YW + 2;
   localparam int PW = c3e_pkg::PIX_W;
   localparam int SW = c3e_pkg::SUM_W;
   localparam int DW = c3e_pkg::DIV_W;
   localparam int OW = c3e_pkg::OFF_W;
   localparam int CFW = c3e_pkg::COEF_W;
   localparam int NT = c3e_pkg::TAPS;

   // configuration registers
   logic [c3e_pkg::REG_W-1:0] kernel_ff [3];
   logic [3:0]                anchor_ff;
   logic [DW-1:0]             divisor_ff;
   logic [OW-1:0]             offset_ff;
   logic [10:0]               fwidth_ff, fheight_ff;

   // settings derived from the registers
   logic [WW-1:0] w_ff, w_in;
   logic [HW-1:0] h_in;
   logic [XW-1:0] wm1_ff, wm1_in;
   logic [YW-1:0] hm1_ff, hm1_in;
   logic [CW-1:0] total_ff, total_in;
   logic [CW-1:0] lag_ff, lag_in;
   logic [1:0]    arow_ff, arow_in, acol_ff, acol_in;
   logic [DW-1:0] div_ff, div_in;
   logic [3:0]    anc;

   c3e_pkg::state_type state_ff, state_in;

   logic [3*PW-1:0] pix_ff;
   logic            drain_ff;
   logic [CW-1:0]   items_ff, items_in;
   logic [CW-1:0]   q_ff, q_in;
   logic [XW-1:0]   ox_ff, ox_in;
   logic [YW-1:0]   oy_ff, oy_in;
   logic [1:0]      ky_ff, ky_in, kx_ff, kx_in;
   logic            tap_vld_ff;
   logic [3*PW-1:0] rd_data_ff;
   logic            rsp_vld_ff, rsp_vld_in;
   logic [3*PW-1:0] rsp_data_ff;
   logic            rsp_last_ff;

   logic [3*PW-1:0] ring_mem [RING_DEPTH];

   logic            mem_we, items_inc, tap_issue, div_start, out_load, frame_done;
   logic [AW-1:0]   rd_addr;

   logic [YS-1:0]   yy, yc, dy_full;
   logic [XS-1:0]   xx, xc, dx_full;
   logic [2:0]      dy, dx, dy_mag;
   logic [AW-1:0]   w_a, row_ofs, row_mag;

   logic                vld_chain [NT+1];
   c3e_pkg::sum_type    sum_chain [NT+1];
   logic [2:0]          div_done;
   logic signed [SW-1:0] quo [3];
   logic [PW-1:0]       chan [3];

   // ------------------------------------------------------------ registers
   always_ff @(posedge clock) begin
      if (reset) begin
         kernel_ff[0] <= '0;
         kernel_ff[1] <= c3e_pkg::REG_W'(65536);
         kernel_ff[2] <= '0;
         anchor_ff    <= 4'd4;
         divisor_ff   <= DW'(1);
         offset_ff    <= '0;
         fwidth_ff    <= 11'd1024;
         fheight_ff   <= 11'd1024;
      end else if (csr_we) begin
         case (csr_index)
            c3e_pkg::CSR_KERNEL_TOP:    kernel_ff[0] <= csr_wdata;
            c3e_pkg::CSR_KERNEL_MIDDLE: kernel_ff[1] <= csr_wdata;
            c3e_pkg::CSR_KERNEL_BOTTOM: kernel_ff[2] <= csr_wdata;
            c3e_pkg::CSR_ANCHOR:        anchor_ff    <= csr_wdata[3:0];
            c3e_pkg::CSR_DIVISOR:       divisor_ff   <= csr_wdata[DW-1:0];
            c3e_pkg::CSR_OFFSET:        offset_ff    <= csr_wdata[OW-1:0];
            c3e_pkg::CSR_WIDTH:         fwidth_ff    <= csr_wdata[10:0];
            c3e_pkg::CSR_HEIGHT:        fheight_ff   <= csr_wdata[10:0];
            default: ;
         endcase
      end
   end

   // frame size clamped to 1..max, anchor to 8, divisor zero acts as one
   always_comb begin
      if (fwidth_ff == 11'd0) begin
         w_in = WW'(1);
      end else if (32'(fwidth_ff) > MAX_WIDTH) begin
         w_in = WW'(MAX_WIDTH);
      end else begin
         w_in = WW'(fwidth_ff);
      end
      if (fheight_ff == 11'd0) begin
         h_in = HW'(1);
      end else if (32'(fheight_ff) > MAX_HEIGHT) begin
         h_in = HW'(MAX_HEIGHT);
      end else begin
         h_in = HW'(fheight_ff);
      end
      wm1_in = XW'(w_in - WW'(1));
      hm1_in = YW'(h_in - HW'(1));
      total_in = CW'(w_in) * CW'(h_in);
      anc = (anchor_ff > 4'd8) ? 4'd8 : anchor_ff;
      if (anc >= 4'd6) begin
         arow_in = 2'd2;
      end else if (anc >= 4'd3) begin
         arow_in = 2'd1;
      end else begin
         arow_in = 2'd0;
      end
      acol_in = 2'(anc - 4'(3 * arow_in));
      case (arow_in)
         2'd0:    lag_in = CW'(w_in) << 1;
         2'd1:    lag_in = CW'(w_in);
         default: lag_in = '0;
      endcase
      lag_in = lag_in + CW'(2'd2 - acol_in);
      div_in = (divisor_ff == '0) ? DW'(1) : divisor_ff;
   end

   always_ff @(posedge clock) begin
      w_ff     <= w_in;
      wm1_ff   <= wm1_in;
      hm1_ff   <= hm1_in;
      total_ff <= total_in;
      lag_ff   <= lag_in;
      arow_ff  <= arow_in;
      acol_ff  <= acol_in;
      div_ff   <= div_in;
   end

   // ------------------------------------------------------------ sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         c3e_pkg::ST_IDLE:  if (req_tvalid) state_in = c3e_pkg::ST_PREP;
         c3e_pkg::ST_PREP:  state_in = c3e_pkg::ST_STORE;
         c3e_pkg::ST_STORE: begin
            if (items_ff < total_ff && drain_ff) begin
               state_in = c3e_pkg::ST_IDLE;
            end else if (items_ff >= lag_ff) begin
               state_in = c3e_pkg::ST_TAPS;
            end else begin
               state_in = c3e_pkg::ST_IDLE;
            end
         end
         c3e_pkg::ST_TAPS:  if (ky_ff == 2'd2 && kx_ff == 2'd2) state_in = c3e_pkg::ST_SUM;
         c3e_pkg::ST_SUM:   if (vld_chain[NT]) state_in = c3e_pkg::ST_DIV;
         c3e_pkg::ST_DIV:   if (div_done[0]) state_in = c3e_pkg::ST_OUT;
         c3e_pkg::ST_OUT:   if (!rsp_vld_ff || rsp_tready) state_in = c3e_pkg::ST_IDLE;
         default:           state_in = c3e_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      req_tready = 1'b0;
      mem_we     = 1'b0;
      items_inc  = 1'b0;
      tap_issue  = 1'b0;
      div_start  = 1'b0;
      out_load   = 1'b0;
      case (state_ff)
         c3e_pkg::ST_IDLE:  req_tready = 1'b1;
         c3e_pkg::ST_STORE: begin
            // drain inside the frame is ignored, pixel past it only counts
            mem_we    = (items_ff < total_ff) && !drain_ff;
            items_inc = !((items_ff < total_ff) && drain_ff);
         end
         c3e_pkg::ST_TAPS:  tap_issue = 1'b1;
         c3e_pkg::ST_SUM:   div_start = vld_chain[NT];
         c3e_pkg::ST_OUT:   out_load = !rsp_vld_ff || rsp_tready;
         default: ;
      endcase
   end

   assign frame_done = (q_ff + CW'(1)) >= total_ff;

   always_comb begin
      items_in = items_ff;
      q_in     = q_ff;
      ox_in    = ox_ff;
      oy_in    = oy_ff;
      if (items_inc) begin
         items_in = items_ff + CW'(1);
      end
      if (out_load) begin
         if (frame_done) begin
            items_in = '0;
            q_in     = '0;
            ox_in    = '0;
            oy_in    = '0;
         end else begin
            q_in = q_ff + CW'(1);
            if (ox_ff >= wm1_ff) begin
               ox_in = '0;
               oy_in = oy_ff + YW'(1);
            end else begin
               ox_in = ox_ff + XW'(1);
            end
         end
      end
      ky_in = '0;
      kx_in = '0;
      if (tap_issue) begin
         if (kx_ff == 2'd2) begin
            ky_in = ky_ff + 2'd1;
         end else begin
            ky_in = ky_ff;
            kx_in = kx_ff + 2'd1;
         end
      end
      rsp_vld_in = out_load ? 1'b1 : (rsp_tready ? 1'b0 : rsp_vld_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= c3e_pkg::ST_IDLE;
         items_ff   <= '0;
         q_ff       <= '0;
         ox_ff      <= '0;
         oy_ff      <= '0;
         ky_ff      <= '0;
         kx_ff      <= '0;
         tap_vld_ff <= 1'b0;
         rsp_vld_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         items_ff   <= items_in;
         q_ff       <= q_in;
         ox_ff      <= ox_in;
         oy_ff      <= oy_in;
         ky_ff      <= ky_in;
         kx_ff      <= kx_in;
         tap_vld_ff <= tap_issue;
         rsp_vld_ff <= rsp_vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         pix_ff   <= req_tdata;
         drain_ff <= req_tuser;
      end
      if (out_load) begin
         rsp_data_ff <= {chan[2], chan[1], chan[0]};
         rsp_last_ff <= frame_done;
      end
   end

   // ------------------------------------------------------------ tap address
   // clamped coordinate minus output coordinate gives a small step, and
   // the ring address is the output index plus that step
   always_comb begin
      yy = YS'(oy_ff) - YS'(arow_ff) + YS'(ky_ff);
      if (yy[YS-1]) begin
         yc = '0;
      end else if (yy > YS'(hm1_ff)) begin
         yc = YS'(hm1_ff);
      end else begin
         yc = yy;
      end
      dy_full = yc - YS'(oy_ff);
      dy = dy_full[2:0];
      xx = XS'(ox_ff) - XS'(acol_ff) + XS'(kx_ff);
      if (xx[XS-1]) begin
         xc = '0;
      end else if (xx > XS'(wm1_ff)) begin
         xc = XS'(wm1_ff);
      end else begin
         xc = xx;
      end
      dx_full = xc - XS'(ox_ff);
      dx = dx_full[2:0];
      w_a = AW'(w_ff);
      dy_mag = dy[2] ? 3'd0 - dy : dy;
      if (dy_mag[1]) begin
         row_mag = w_a << 1;
      end else if (dy_mag[0]) begin
         row_mag = w_a;
      end else begin
         row_mag = '0;
      end
      row_ofs = dy[2] ? AW'(0) - row_mag : row_mag;
      rd_addr = q_ff[AW-1:0] + row_ofs + {{(AW-3){dx[2]}}, dx};
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         ring_mem[items_ff[AW-1:0]] <= pix_ff;
      end
      if (tap_issue) begin
         rd_data_ff <= ring_mem[rd_addr];
      end
   end

   // ------------------------------------------------------------ cell chain
   assign vld_chain[0] = tap_vld_ff;
   assign sum_chain[0] = '0;

   for (genvar k = 0; k < NT; k++) begin : g_cell
      c3e_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .vld_in      (vld_chain[k]),
         .tap_in      (rd_data_ff),
         .coef        ($signed(kernel_ff[k / 3][CFW * (k % 3) +: CFW])),
         .partial_in  (sum_chain[k]),
         .vld_out     (vld_chain[k + 1]),
         .partial_out (sum_chain[k + 1])
      );
   end

   // ------------------------------------------------------------ division
   c3e_div u_div_red (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_chain[NT].red),
      .divisor  (div_ff),
      .done     (div_done[0]),
      .quotient (quo[0])
   );

   c3e_div u_div_green (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_chain[NT].green),
      .divisor  (div_ff),
      .done     (div_done[1]),
      .quotient (quo[1])
   );

   c3e_div u_div_blue (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (sum_chain[NT].blue),
      .divisor  (div_ff),
      .done     (div_done[2]),
      .quotient (quo[2])
   );

   function automatic logic [PW-1:0] sat_level(input logic signed [SW-1:0] qv,
                                               input logic signed [OW-1:0] ov);
      logic signed [SW:0] v;
      v = (SW+1)'(qv) + (SW+1)'(ov);
      if (v < 0) begin
         return '0;
      end else if (v > 255) begin
         return '1;
      end else begin
         return v[PW-1:0];
      end
   endfunction

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         chan[i] = sat_level(quo[i], $signed(offset_ff));
      end
   end

   assign rsp_tvalid = rsp_vld_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;

   // ------------------------------------------------------------ assertions
   a_div_lanes_agree: assert property (@(posedge clock) disable iff (reset)
      div_done[0] == div_done[1] && div_done[0] == div_done[2])
      else $error("divider lanes out of step");

   a_div_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_done[0] |-> state_ff == c3e_pkg::ST_DIV)
      else $error("divider finished outside its state");

   // the chain end stays valid into the divide
   a_chain_end_in_sum: assert property (@(posedge clock) disable iff (reset)
      vld_chain[NT] |-> state_ff == c3e_pkg::ST_SUM || state_ff == c3e_pkg::ST_DIV)
      else $error("cell chain finished outside its state");

   a_tap_index_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == c3e_pkg::ST_TAPS |-> ky_ff != 2'd3 && kx_ff != 2'd3)
      else $error("tap index out of range");

endmodule

// ===== sim/conv3x3_rgb_edge_replicate_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// conv3x3_rgb_edge_replicate_tb: self-checking bench of the 3x3 rgb filter
// streams small frames under many kernel, anchor, divisor, offset and size
// settings, predicts every filtered pixel in a local model of the line ring
// and compares each response field by field, with random gaps on both sides
// ----------------------------------------------------------------------------
module conv3x3_rgb_edge_replicate_tb;

   localparam int MAXW      = 1024;
   localparam int MAXH      = 1024;
   localparam int RING      = 2 * MAXW + 4;
   localparam int IDLE_WAIT = 80;
   localparam int HOLD_LEN  = 400;

   typedef struct {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
      logic       last;
   } pixel_out_type;

   logic                clock      = 1'b0;
   logic                reset      = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [23:0]         req_tdata  = '0;   // pixel_red, pixel_green, pixel_blue
   logic                req_tuser  = 1'b0; // drain
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [23:0]         rsp_tdata;         // out_red, out_green, out_blue
   logic                rsp_tlast;
   logic                csr_we     = 1'b0;
   c3e_pkg::csr_index_type csr_index = c3e_pkg::CSR_KERNEL_TOP;
   logic [c3e_pkg::REG_W-1:0] csr_wdata = '0;

   conv3x3_rgb_edge_replicate dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tlast(rsp_tlast),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   always #6 clock = ~clock;

   // register mirror and filter state
   logic [47:0]   kernel_rows [3];
   logic [3:0]    anchor_reg;
   logic [9:0]    divisor_reg;
   logic [10:0]   offset_reg;
   logic [10:0]   width_reg;
   logic [10:0]   height_reg;
   logic [23:0]   line_ring [RING];
   int            pixels_taken;
   int            pixels_filtered;

   pixel_out_type filtered_q [$];
   int            fail_count = 0;
   int            requests_sent = 0;
   bit            send_steady = 0;
   bit            rsp_steady = 0;
   bit            hold_start = 0;
   int            hold_left = 0;
   int            rsp_stall_left = 0;

   function automatic int eff_width();
      return width_reg < 1 ? 1 : (width_reg > MAXW ? MAXW : int'(width_reg));
   endfunction

   function automatic int eff_height();
      return height_reg < 1 ? 1 : (height_reg > MAXH ? MAXH : int'(height_reg));
   endfunction

   function automatic int eff_anchor();
      return anchor_reg > 8 ? 8 : int'(anchor_reg);
   endfunction

   function automatic int frame_lag();
      return (2 - eff_anchor() / 3) * eff_width() + (2 - eff_anchor() % 3);
   endfunction

   function automatic logic [7:0] saturate_level(int total);
      int div, off, v;
      div = divisor_reg == 0 ? 1 : int'(divisor_reg);
      off = int'($signed(offset_reg));
      v = total / div + off;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      return v[7:0];
   endfunction

   // one accepted request through the filter model
   task automatic filter_step(input logic [23:0] pix, input logic drain);
      int w, h, arow, acol, total, ox, oy, x, y, c;
      int sr, sg, sb;
      logic [23:0] tap;
      pixel_out_type res;
      w = eff_width();
      h = eff_height();
      arow = eff_anchor() / 3;
      acol = eff_anchor() % 3;
      total = w * h;
      sr = 0; sg = 0; sb = 0;
      if (pixels_taken < total) begin
         if (drain) return;
         line_ring[pixels_taken % RING] = {pix[7:0], pix[15:8], pix[23:16]};
      end
      pixels_taken++;
      if (pixels_taken <= frame_lag()) return;
      ox = pixels_filtered % w;
      oy = pixels_filtered / w;
      for (int ky = 0; ky < 3; ky++) begin
         for (int kx = 0; kx < 3; kx++) begin
            y = oy - arow + ky;
            y = y < 0 ? 0 : (y > h - 1 ? h - 1 : y);
            x = ox - acol + kx;
            x = x < 0 ? 0 : (x > w - 1 ? w - 1 : x);
            tap = line_ring[(y * w + x) % RING];
            c = int'($signed(kernel_rows[ky][16*kx +: 16]));
            sr += int'(tap[23:16]) * c;
            sg += int'(tap[15:8]) * c;
            sb += int'(tap[7:0]) * c;
         end
      end
      res.red = saturate_level(sr);
      res.green = saturate_level(sg);
      res.blue = saturate_level(sb);
      res.last = (pixels_filtered + 1 >= total);
      filtered_q.push_back(res);
      if (res.last) begin
         pixels_taken = 0;
         pixels_filtered = 0;
      end else begin
         pixels_filtered++;
      end
   endtask

   function automatic int pick_gap();
      int r;
      if (send_steady) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // called at a rising edge, returns at the edge of acceptance
   task automatic send_request(input logic [23:0] pix, input logic drain);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= pix;
      req_tuser <= drain;
      do @(posedge clock); while (!req_tready);
      requests_sent++;
      filter_step(pix, drain);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (filtered_q.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_write(input c3e_pkg::csr_index_type idx,
                            input logic [c3e_pkg::REG_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         c3e_pkg::CSR_KERNEL_TOP:    kernel_rows[0] = val;
         c3e_pkg::CSR_KERNEL_MIDDLE: kernel_rows[1] = val;
         c3e_pkg::CSR_KERNEL_BOTTOM: kernel_rows[2] = val;
         c3e_pkg::CSR_ANCHOR:        anchor_reg = val[3:0];
         c3e_pkg::CSR_DIVISOR:       divisor_reg = val[9:0];
         c3e_pkg::CSR_OFFSET:        offset_reg = val[10:0];
         c3e_pkg::CSR_WIDTH:         width_reg = val[10:0];
         c3e_pkg::CSR_HEIGHT:        height_reg = val[10:0];
         default: ;
      endcase
   endtask

   task automatic apply_settings(input logic [47:0] k0, k1, k2, input int anc, div, off,
                                 input int w, h);
      wait_idle();
      csr_write(c3e_pkg::CSR_KERNEL_TOP, k0);
      csr_write(c3e_pkg::CSR_KERNEL_MIDDLE, k1);
      csr_write(c3e_pkg::CSR_KERNEL_BOTTOM, k2);
      csr_write(c3e_pkg::CSR_ANCHOR, c3e_pkg::REG_W'(anc));
      csr_write(c3e_pkg::CSR_DIVISOR, c3e_pkg::REG_W'(div));
      csr_write(c3e_pkg::CSR_OFFSET, c3e_pkg::REG_W'(off & 11'h7ff));
      csr_write(c3e_pkg::CSR_WIDTH, c3e_pkg::REG_W'(w));
      csr_write(c3e_pkg::CSR_HEIGHT, c3e_pkg::REG_W'(h));
      csr_we <= 1'b0;
   endtask

   function automatic logic [7:0] rand_chan();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 8'h00;
      if (r == 1) return 8'hff;
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic logic [23:0] rand_pixel();
      return {rand_chan(), rand_chan(), rand_chan()};
   endfunction

   function automatic logic [15:0] rand_coef();
      int r;
      r = $urandom_range(0, 9);
      if (r == 0) return 16'h8000;
      if (r == 1) return 16'h7fff;
      if (r == 2) return 16'($urandom);
      return 16'($signed($urandom_range(0, 16)) - 8);
   endfunction

   function automatic logic [47:0] rand_row();
      return {rand_coef(), rand_coef(), rand_coef()};
   endfunction

   // whole frame: pixels with ignored drains mixed in, then the flush
   task automatic run_frame(input int noise_pct, input int pause_at);
      int total, lag;
      total = eff_width() * eff_height();
      lag = frame_lag();
      for (int i = 0; i < total; i++) begin
         if (i == pause_at) begin
            req_tvalid <= 1'b0;
            do @(posedge clock); while (filtered_q.size() != 0);
         end
         if ($urandom_range(0, 99) < noise_pct) send_request(rand_pixel(), 1'b1);
         send_request(rand_pixel(), 1'b0);
      end
      // a pixel past the frame end counts as a flush step too
      for (int i = 0; i < lag; i++)
         send_request(rand_pixel(), $urandom_range(0, 3) != 0);
   endtask

   task automatic test_directed();
      apply_settings(48'h0, 48'h0000_0001_0000, 48'h0, 4, 1, 0, 3, 2);
      run_frame(20, -1);
      apply_settings(48'h8000_7fff_8000, 48'h7fff_8000_7fff, 48'h8000_8000_8000,
                     0, 1023, -1024, 0, 3);
      run_frame(0, -1);
      apply_settings(rand_row(), rand_row(), rand_row(), 15, 0, 1023, 2, 2);
      run_frame(0, -1);
   endtask

   task automatic test_random_frames();
      int w, h, div, off;
      while (requests_sent < 600) begin
         w = $urandom_range(0, 9) == 0 ? $urandom_range(9, 48) : $urandom_range(1, 8);
         h = $urandom_range(1, 6);
         case ($urandom_range(0, 3))
            0: div = $urandom_range(0, 1023);
            1: div = 1023;
            default: div = $urandom_range(1, 16);
         endcase
         off = $urandom_range(0, 1) ? $urandom_range(0, 2047) : $urandom_range(0, 64) - 32;
         apply_settings(rand_row(), rand_row(), rand_row(),
                        $urandom_range(0, 7) == 0 ? $urandom_range(9, 15) : $urandom_range(0, 8),
                        div, off, w, h);
         send_steady = ($urandom_range(0, 4) == 0);
         rsp_steady = ($urandom_range(0, 4) == 0);
         run_frame(5, -1);
      end
      send_steady = 0;
      rsp_steady = 0;
   endtask

   task automatic test_output_hold();
      apply_settings(rand_row(), rand_row(), rand_row(), 4, 3, 10, 6, 5);
      send_steady = 1;
      hold_start = 1;
      run_frame(0, -1);
      send_steady = 0;
   endtask

   task automatic test_sender_pause();
      apply_settings(rand_row(), rand_row(), rand_row(), 2, 5, -20, 5, 4);
      run_frame(5, 15);
   endtask

   task automatic test_size_limits();
      // oversized width falls back to the maximum, zero height to one row
      apply_settings(rand_row(), rand_row(), rand_row(), 8, 7, 0, 2047, 0);
      run_frame(0, -1);
   endtask

   always @(posedge clock) begin
      pixel_out_type exp_px;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (filtered_q.size() == 0) begin
            $error("response with no filtered pixel pending: %h", rsp_tdata);
            fail_count++;
         end else begin
            exp_px = filtered_q.pop_front();
            if (rsp_tdata[7:0] !== exp_px.red) begin
               $error("out_red expected %0d actual %0d", exp_px.red, rsp_tdata[7:0]);
               fail_count++;
            end
            if (rsp_tdata[15:8] !== exp_px.green) begin
               $error("out_green expected %0d actual %0d", exp_px.green, rsp_tdata[15:8]);
               fail_count++;
            end
            if (rsp_tdata[23:16] !== exp_px.blue) begin
               $error("out_blue expected %0d actual %0d", exp_px.blue, rsp_tdata[23:16]);
               fail_count++;
            end
            if (rsp_tlast !== exp_px.last) begin
               $error("frame_done expected %0d actual %0d", exp_px.last, rsp_tlast);
               fail_count++;
            end
         end
      end
      if (hold_start) begin
         hold_left = HOLD_LEN;
         hold_start = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_stall_left > 0) begin
         rsp_stall_left--;
         rsp_tready <= 1'b0;
      end else if (!rsp_steady && $urandom_range(0, 99) < 15) begin
         rsp_stall_left = $urandom_range(0, 9) == 0 ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 2);
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   initial begin
      kernel_rows[0] = 48'h0;
      kernel_rows[1] = 48'h0000_0001_0000;
      kernel_rows[2] = 48'h0;
      anchor_reg = 4;
      divisor_reg = 1;
      offset_reg = 0;
      width_reg = 1024;
      height_reg = 1024;
      pixels_taken = 0;
      pixels_filtered = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_frames();
      test_output_hold();
      test_sender_pause();
      test_size_limits();
      wait_idle();
      if (fail_count == 0 && filtered_q.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   initial begin
      #40ms;
      $display("CHECKS FAILED");
      $finish;
   end

endmodule
